// ----- design/tfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared types and constants of the telemetry frame supervisor.
// ----------------------------------------------------------------------------
package tfs_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 63;
  localparam logic [7:0] SYNC_RESET = 8'h55;
  localparam logic [15:0] WDOG_RESET = 16'd20;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    REG_SYNC = 1'b0,
    REG_WDOG = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_BOOT      = 3'd0,
    MODE_SELF_TEST = 3'd1,
    MODE_NORMAL    = 3'd2,
    MODE_DEGRADED  = 3'd3,
    MODE_FAIL_SAFE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    EVT_OK   = 2'd0,
    EVT_BAD  = 2'd1,
    EVT_WDOG = 2'd2
  } evt_code_t;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    logic      vld;
    evt_code_t code;
  } event_t;

  typedef struct packed {
    mode_t mode;
    logic  fault;
  } sup_state_t;

endpackage

// ----- design/tfs_deframer.sv -----
// ----------------------------------------------------------------------------
// tfs_deframer
// Sync, length, payload and checksum deframer; flags good and bad frames.
// ----------------------------------------------------------------------------
module tfs_deframer #(
  parameter int unsigned MaxPayload = tfs_pkg::MAX_PAYLOAD_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [7:0]      data_byte,
  input  logic [7:0]      sync_value,
  output tfs_pkg::event_t ev
);

  localparam int unsigned LenW = $clog2(MaxPayload + 1);

  typedef enum logic [1:0] {
    PH_SYNC  = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  phase_t            phase;
  phase_t            phase_next;
  logic [7:0]        first_byte;
  logic [7:0]        first_byte_next;
  logic [LenW-1:0]   bytes_left;
  logic [LenW-1:0]   bytes_left_next;
  logic [7:0]        running_sum;
  logic [7:0]        running_sum_next;

  always_comb begin
    phase_next       = phase;
    first_byte_next  = first_byte;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    ev.vld           = 1'b0;
    ev.code          = tfs_pkg::EVT_OK;
    unique case (phase)
      PH_SYNC: begin
        first_byte_next  = data_byte;
        running_sum_next = data_byte;
        phase_next       = PH_LEN;
      end
      PH_LEN: begin
        if ((first_byte != sync_value) || (data_byte > 8'(MaxPayload))) begin
          phase_next = PH_SYNC;
          ev.vld     = 1'b1;
          ev.code    = tfs_pkg::EVT_BAD;
        end else begin
          running_sum_next = running_sum + data_byte;
          bytes_left_next  = data_byte[LenW-1:0];
          phase_next       = (data_byte != 8'd0) ? PH_BODY : PH_CHECK;
        end
      end
      PH_BODY: begin
        running_sum_next = running_sum + data_byte;
        bytes_left_next  = bytes_left - 1'b1;
        if (bytes_left == LenW'(1)) begin
          phase_next = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_next = PH_SYNC;
        ev.vld     = 1'b1;
        ev.code    = (data_byte == running_sum) ? tfs_pkg::EVT_OK : tfs_pkg::EVT_BAD;
      end
      default: begin
        phase_next = PH_SYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC;
      first_byte  <= 8'd0;
      bytes_left  <= '0;
      running_sum <= 8'd0;
    end else if (en) begin
      phase       <= phase_next;
      first_byte  <= first_byte_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

endmodule

// ----- design/tfs_watchdog.sv -----
// ----------------------------------------------------------------------------
// tfs_watchdog
// Tick counter; fires a watchdog event every period ticks.
// ----------------------------------------------------------------------------
module tfs_watchdog (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [15:0]     watchdog_period,
  output tfs_pkg::event_t ev
);

  logic [15:0] tick_count;
  logic [16:0] count_inc;

  assign count_inc = {1'b0, tick_count} + 17'd1;
  assign ev.vld    = (count_inc >= {1'b0, watchdog_period});
  assign ev.code   = ev.vld ? tfs_pkg::EVT_WDOG : tfs_pkg::EVT_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= 16'd0;
    end else if (en) begin
      tick_count <= ev.vld ? 16'd0 : count_inc[15:0];
    end
  end

endmodule

// ----- design/tfs_supervisor.sv -----
// ----------------------------------------------------------------------------
// tfs_supervisor
// System mode and fault latch, moved by packet and watchdog events.
// ----------------------------------------------------------------------------
module tfs_supervisor (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  tfs_pkg::event_t     ev,
  output tfs_pkg::sup_state_t st_next
);

  tfs_pkg::sup_state_t st;

  always_comb begin
    st_next = st;
    if (ev.vld) begin
      if (st.mode == tfs_pkg::MODE_BOOT) begin
        st_next.mode = tfs_pkg::MODE_SELF_TEST;
      end else if (st.mode == tfs_pkg::MODE_SELF_TEST) begin
        st_next.mode = tfs_pkg::MODE_NORMAL;
      end
      if (ev.code == tfs_pkg::EVT_BAD) begin
        st_next.fault = 1'b1;
        st_next.mode  = tfs_pkg::MODE_DEGRADED;
      end
      if ((ev.code == tfs_pkg::EVT_WDOG) && st.fault) begin
        st_next.mode = tfs_pkg::MODE_FAIL_SAFE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode  <= tfs_pkg::MODE_BOOT;
      st.fault <= 1'b0;
    end else if (en) begin
      st <= st_next;
    end
  end

endmodule

// ----- design/telemetry_frame_supervisor.sv -----
// ----------------------------------------------------------------------------
// telemetry_frame_supervisor
// Deframer, watchdog and system supervisor behind a two-register pipeline.
// ----------------------------------------------------------------------------
// Each request is a received byte or a timer tick and gives exactly one
// result: the system state after it, the fault latch and any event raised.
// A request is registered on input, processed combinationally by the deframer,
// watchdog and supervisor, and held in the result register; one request per
// cycle is sustained while the receiver keeps out_ready high. Registers:
// sync value at 0x0, watchdog period at 0x4.
// ----------------------------------------------------------------------------
module telemetry_frame_supervisor #(
  parameter int unsigned MAX_PAYLOAD = tfs_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tfs_pkg::APB_AW-1:0] paddr,
  input  logic [tfs_pkg::APB_DW-1:0] pwdata,
  output logic [tfs_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       opcode,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 sys_state,
  output logic                       fault_latched,
  output logic                       event_valid,
  output logic [1:0]                 event_code
);

  logic [7:0]  sync_value;
  logic [15:0] watchdog_period;

  logic        req_vld;
  logic        req_op;
  logic [7:0]  req_byte;
  logic        advance;

  tfs_pkg::event_t     frame_ev;
  tfs_pkg::event_t     wdog_ev;
  tfs_pkg::event_t     ev;
  tfs_pkg::sup_state_t st_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value      <= tfs_pkg::SYNC_RESET;
      watchdog_period <= tfs_pkg::WDOG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (tfs_pkg::reg_idx_t'(paddr[2]))
        tfs_pkg::REG_SYNC: sync_value      <= pwdata[7:0];
        tfs_pkg::REG_WDOG: watchdog_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (tfs_pkg::reg_idx_t'(paddr[2]))
      tfs_pkg::REG_SYNC: prdata = {24'd0, sync_value};
      tfs_pkg::REG_WDOG: prdata = {16'd0, watchdog_period};
      default:           prdata = '0;
    endcase
  end

  assign advance  = req_vld && (!out_valid || out_ready);
  assign in_ready = !req_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (in_ready) begin
      req_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_op   <= opcode;
      req_byte <= data_byte;
    end
  end

  tfs_deframer #(
    .MaxPayload(MAX_PAYLOAD)
  ) u_deframer (
    .clk       (clk),
    .rst       (rst),
    .en        (advance && (req_op == tfs_pkg::OP_BYTE)),
    .data_byte (req_byte),
    .sync_value(sync_value),
    .ev        (frame_ev)
  );

  tfs_watchdog u_watchdog (
    .clk            (clk),
    .rst            (rst),
    .en             (advance && (req_op == tfs_pkg::OP_TICK)),
    .watchdog_period(watchdog_period),
    .ev             (wdog_ev)
  );

  assign ev = (req_op == tfs_pkg::OP_TICK) ? wdog_ev : frame_ev;

  tfs_supervisor u_supervisor (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .ev     (ev),
    .st_next(st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sys_state     <= st_next.mode;
      fault_latched <= st_next.fault;
      event_valid   <= ev.vld;
      event_code    <= ev.vld ? ev.code : tfs_pkg::EVT_OK;
    end
  end

endmodule

// ----- design/tfs_checker.sv -----
// ----------------------------------------------------------------------------
// tfs_checker
// Port-level checks of the telemetry frame supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module tfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] sys_state,
  input logic       fault_latched,
  input logic       event_valid,
  input logic [1:0] event_code
);

  a_quiet_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !event_valid) |-> (event_code == tfs_pkg::EVT_OK))
    else $error("event code set without event");

  a_bad_degrades: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_valid && (event_code == tfs_pkg::EVT_BAD)) |->
      (fault_latched && (sys_state == tfs_pkg::MODE_DEGRADED)))
    else $error("bad packet did not latch fault and degrade");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    ($past(out_valid && fault_latched) && out_valid) |-> fault_latched)
    else $error("fault latch cleared");

  a_failsafe_needs_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (sys_state == tfs_pkg::MODE_FAIL_SAFE)) |-> fault_latched)
    else $error("fail safe without latched fault");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sys_state) &&
      $stable(event_code)))
    else $error("stalled result changed");

endmodule

bind telemetry_frame_supervisor tfs_checker u_tfs_checker (.*);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the telemetry frame supervisor.
// ----------------------------------------------------------------------------
// A queue of link requests (bytes and ticks) feeds a valid/ready driver. A
// monitor predicts each accepted request's result from a local model of the
// deframer, watchdog and supervisor, and compares it field by field with the
// result stream. A directed opening covers the frame, sync, length, checksum
// and watchdog corners. Random phases follow, each under its own register
// settings and handshake idling, one with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_LEN   = tfs_pkg::MAX_PAYLOAD_DEF;
  localparam int          DRAIN_CYC = 4;
  localparam int          IDLE_LIMIT = 3000;
  localparam int          HOLD_CYC  = 250;
  localparam int          PHASE_ITEMS = 100;

  typedef enum logic [1:0] {
    PH_SYNC  = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } frame_phase_t;

  typedef struct packed {
    tfs_pkg::opcode_t op;
    logic [7:0]       b;
  } link_req_t;

  typedef struct packed {
    tfs_pkg::mode_t     state;
    logic               fault;
    logic               ev;
    tfs_pkg::evt_code_t code;
  } sup_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [tfs_pkg::APB_AW-1:0] paddr = '0;
  logic [tfs_pkg::APB_DW-1:0] pwdata = '0;
  logic [tfs_pkg::APB_DW-1:0] prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       opcode = 1'b0;
  logic [7:0]                 data_byte = 8'h00;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 sys_state;
  logic                       fault_latched;
  logic                       event_valid;
  logic [1:0]                 event_code;

  link_req_t   req_q[$];
  sup_result_t sup_exp_q[$];
  int          req_total = 0;
  int          req_done = 0;
  int          err_cnt = 0;
  int          idle_cyc = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        in_fire = 1'b0;
  logic        pressure_on = 1'b0;
  logic        pressure_done = 1'b0;
  int          hold_left = 0;

  logic [7:0]     cfg_sync = tfs_pkg::SYNC_RESET;
  logic [15:0]    cfg_period = tfs_pkg::WDOG_RESET;
  tfs_pkg::mode_t sv_mode = tfs_pkg::MODE_BOOT;
  logic           sv_fault = 1'b0;
  frame_phase_t   sv_phase = PH_SYNC;
  logic [7:0]     sv_first = 8'h00;
  logic [7:0]     sv_left = 8'h00;
  logic [7:0]     sv_sum = 8'h00;
  logic [15:0]    sv_ticks = 16'h0000;

  telemetry_frame_supervisor #(
    .MAX_PAYLOAD(tfs_pkg::MAX_PAYLOAD_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sys_state    (sys_state),
    .fault_latched(fault_latched),
    .event_valid  (event_valid),
    .event_code   (event_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic sup_result_t step_supervisor(tfs_pkg::opcode_t op, logic [7:0] b);
    sup_result_t        r;
    logic               hit;
    tfs_pkg::evt_code_t code;
    logic [16:0]        next_ticks;
    hit = 1'b0;
    code = tfs_pkg::EVT_OK;
    next_ticks = {1'b0, sv_ticks} + 17'd1;
    if (op == tfs_pkg::OP_BYTE) begin
      case (sv_phase)
        PH_SYNC: begin
          sv_first = b;
          sv_sum = b;
          sv_phase = PH_LEN;
        end
        PH_LEN: begin
          if (sv_first != cfg_sync || b > MAX_LEN) begin
            sv_phase = PH_SYNC;
            hit = 1'b1;
            code = tfs_pkg::EVT_BAD;
          end else begin
            sv_sum = sv_sum + b;
            sv_left = b;
            sv_phase = (b != 8'h00) ? PH_BODY : PH_CHECK;
          end
        end
        PH_BODY: begin
          sv_sum = sv_sum + b;
          sv_left = sv_left - 8'd1;
          if (sv_left == 8'h00) sv_phase = PH_CHECK;
        end
        default: begin
          sv_phase = PH_SYNC;
          hit = 1'b1;
          code = (b == sv_sum) ? tfs_pkg::EVT_OK : tfs_pkg::EVT_BAD;
        end
      endcase
    end else if (next_ticks >= {1'b0, cfg_period}) begin
      sv_ticks = 16'h0000;
      hit = 1'b1;
      code = tfs_pkg::EVT_WDOG;
    end else begin
      sv_ticks = next_ticks[15:0];
    end
    if (hit) begin
      if (sv_mode == tfs_pkg::MODE_BOOT) sv_mode = tfs_pkg::MODE_SELF_TEST;
      else if (sv_mode == tfs_pkg::MODE_SELF_TEST) sv_mode = tfs_pkg::MODE_NORMAL;
      if (code == tfs_pkg::EVT_BAD) begin
        sv_fault = 1'b1;
        sv_mode = tfs_pkg::MODE_DEGRADED;
      end
      if (code == tfs_pkg::EVT_WDOG && sv_fault) sv_mode = tfs_pkg::MODE_FAIL_SAFE;
    end
    r.state = sv_mode;
    r.fault = sv_fault;
    r.ev = hit;
    r.code = code;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(negedge clk) begin
    link_req_t nx;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nx = req_q.pop_front();
        in_valid <= 1'b1;
        opcode <= nx.op;
        data_byte <= nx.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (pressure_on && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYC;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sup_result_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        sup_exp_q.push_back(step_supervisor(tfs_pkg::opcode_t'(opcode), data_byte));
        req_done++;
      end
      if (out_valid && out_ready) begin
        if (sup_exp_q.size() == 0) begin
          $display("%0t: result with no request pending: state %0d event %0d/%0d",
                   $time, sys_state, event_valid, event_code);
          err_cnt++;
        end else begin
          want = sup_exp_q.pop_front();
          check_field("sys_state", want.state, sys_state);
          check_field("fault_latched", want.fault, fault_latched);
          check_field("event_valid", want.ev, event_valid);
          check_field("event_code", want.code, event_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc + 1 >= IDLE_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("** telemetry_frame_supervisor: FAILED **");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic push_req(tfs_pkg::opcode_t op, logic [7:0] b);
    link_req_t r;
    r.op = op;
    r.b = b;
    req_q.push_back(r);
    req_total++;
  endtask

  task automatic maybe_tick();
    if ($urandom_range(0, 11) == 0) push_req(tfs_pkg::OP_TICK, 8'($urandom));
  endtask

  task automatic push_frame(logic [7:0] head, logic [7:0] len, bit spoil);
    logic [7:0] sum;
    logic [7:0] pay;
    sum = head + len;
    push_req(tfs_pkg::OP_BYTE, head);
    maybe_tick();
    push_req(tfs_pkg::OP_BYTE, len);
    for (int i = 0; i < len; i++) begin
      maybe_tick();
      pay = 8'($urandom);
      sum = sum + pay;
      push_req(tfs_pkg::OP_BYTE, pay);
    end
    maybe_tick();
    push_req(tfs_pkg::OP_BYTE, spoil ? (sum ^ (8'd1 << $urandom_range(0, 7))) : sum);
  endtask

  task automatic push_random();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, MAX_LEN) : $urandom_range(0, 6);
    if (pick < 60) begin
      push_frame(cfg_sync, 8'(len), 1'b0);
    end else if (pick < 68) begin
      push_frame(cfg_sync, 8'(len), 1'b1);
    end else if (pick < 74) begin
      push_req(tfs_pkg::OP_BYTE, cfg_sync ^ 8'($urandom_range(1, 255)));
      push_req(tfs_pkg::OP_BYTE, 8'($urandom));
    end else if (pick < 80) begin
      push_req(tfs_pkg::OP_BYTE, cfg_sync);
      push_req(tfs_pkg::OP_BYTE, 8'($urandom_range(MAX_LEN + 1, 255)));
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 4)) push_req(tfs_pkg::OP_TICK, 8'($urandom));
    end else begin
      push_req(tfs_pkg::OP_BYTE, 8'($urandom));
    end
  endtask

  task automatic reg_write(tfs_pkg::reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tfs_pkg::APB_AW'(int'(idx) * 4);
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == tfs_pkg::REG_SYNC) cfg_sync = val[7:0];
    else cfg_period = val[15:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (req_done != req_total || sup_exp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: boot, self test, normal, then a watchdog without fault
    push_req(tfs_pkg::OP_TICK, 8'hFF);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'h00);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'h01);
    push_req(tfs_pkg::OP_BYTE, 8'hFF);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    repeat (19) push_req(tfs_pkg::OP_TICK, 8'($urandom));
    wait_idle();

    reg_write(tfs_pkg::REG_WDOG, 32'd2);
    @(posedge clk);
    push_req(tfs_pkg::OP_BYTE, 8'h00);
    push_req(tfs_pkg::OP_BYTE, 8'hFF);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'd64);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'hFF);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'h00);
    push_req(tfs_pkg::OP_BYTE, 8'h00);
    push_req(tfs_pkg::OP_TICK, 8'h00);
    push_req(tfs_pkg::OP_TICK, 8'h00);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'h00);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    push_req(tfs_pkg::OP_BYTE, 8'd64);
    push_req(tfs_pkg::OP_TICK, 8'hFF);
    push_req(tfs_pkg::OP_TICK, 8'h00);
    // hold a half frame across a sync register change
    push_req(tfs_pkg::OP_BYTE, 8'h55);
    wait_idle();
    reg_write(tfs_pkg::REG_SYNC, 32'hAA);
    @(posedge clk);
    push_req(tfs_pkg::OP_BYTE, 8'h00);
    wait_idle();

    reg_write(tfs_pkg::REG_WDOG, 32'd0);
    @(posedge clk);
    repeat (3) push_req(tfs_pkg::OP_TICK, 8'($urandom));
    wait_idle();
    reg_write(tfs_pkg::REG_WDOG, 32'd1000);
    @(posedge clk);
    repeat (4) push_req(tfs_pkg::OP_TICK, 8'($urandom));
    wait_idle();
    reg_write(tfs_pkg::REG_WDOG, 32'd2);
    @(posedge clk);
    push_req(tfs_pkg::OP_TICK, 8'($urandom));
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          reg_write(tfs_pkg::REG_SYNC, 32'h00);
          reg_write(tfs_pkg::REG_WDOG, 32'd1);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        1: begin
          reg_write(tfs_pkg::REG_SYNC, 32'hFF);
          reg_write(tfs_pkg::REG_WDOG, 32'd65535);
          send_idle_pct = 58;
          recv_idle_pct = 0;
        end
        2: begin
          reg_write(tfs_pkg::REG_SYNC, 32'($urandom_range(0, 255)));
          reg_write(tfs_pkg::REG_WDOG, 32'($urandom_range(2, 30)));
          send_idle_pct = 0;
          recv_idle_pct = 58;
        end
        3: begin
          reg_write(tfs_pkg::REG_SYNC, 32'($urandom_range(0, 255)));
          reg_write(tfs_pkg::REG_WDOG, 32'($urandom_range(1, 8)));
          send_idle_pct = 6;
          recv_idle_pct = 6;
        end
        default: begin
          reg_write(tfs_pkg::REG_SYNC, 32'(tfs_pkg::SYNC_RESET));
          reg_write(tfs_pkg::REG_WDOG, 32'($urandom_range(3, 25)));
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      @(posedge clk);
      for (int n = req_total + PHASE_ITEMS; req_total < n; ) push_random();
      if (ph == 4) pressure_on = 1'b1;
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("** telemetry_frame_supervisor: PASSED **");
    end else begin
      $display("** telemetry_frame_supervisor: FAILED **");
    end
    $finish;
  end

endmodule
